@@ hw/rtl/tbpc_pkg.sv @@
package tbpc_pkg;

  // number of button lanes, fixed by the two pin levels of a poll transaction
  localparam int NUM_BUTTONS = 2;

  // events one lane can raise per poll, and per poll over all lanes
  localparam int LANE_EV  = 2;
  localparam int MAX_EV   = LANE_EV * NUM_BUTTONS;
  localparam int EV_CNT_W = $clog2(MAX_EV + 1);
  localparam int EV_IDX_W = $clog2(MAX_EV);

  // register map, index = paddr[3:2]
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_DEBOUNCE_0  = 2'd0;
  localparam logic [1:0] REG_LONGPRESS_0 = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_1  = 2'd2;
  localparam logic [1:0] REG_LONGPRESS_1 = 2'd3;

  // per-button press state
  localparam logic [1:0] MODE_REST    = 2'd0;
  localparam logic [1:0] MODE_CAUGHT  = 2'd1;
  localparam logic [1:0] MODE_UNFIRED = 2'd2;
  localparam logic [1:0] MODE_FIRED   = 2'd3;

  // event codes on the output stream
  localparam logic [1:0] EV_DOWN  = 2'd0;
  localparam logic [1:0] EV_UP    = 2'd1;
  localparam logic [1:0] EV_SHORT = 2'd2;
  localparam logic [1:0] EV_LONG  = 2'd3;

  typedef struct packed {
    logic        button;
    logic [1:0]  code;
  } event_t;

  // control from the top level into one lane
  typedef struct packed {
    logic        accept;
    logic        poll;
    logic        sel;
    logic        level;
    logic        poll_en;
    logic        force_rest;
    logic [31:0] now_ms;
  } lane_ctl_t;

  // what one lane found for the current transaction
  typedef struct packed {
    logic                  awaiting;
    logic                  caught;
    logic                  busy;
    logic [1:0]            n;
    logic [LANE_EV-1:0][1:0] code;
  } lane_res_t;

endpackage

@@ hw/rtl/tbpc_lane.sv @@
module tbpc_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbpc_pkg::lane_ctl_t ctl_i,
  input  logic [31:0]         debounce_ms_i,
  input  logic [31:0]         longpress_ms_i,
  output tbpc_pkg::lane_res_t res_o
);
  import tbpc_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic        latch_q, latch_d;
  logic [31:0] start_q, start_d;
  logic [31:0] rel_q, rel_d;
  logic [31:0] length;
  logic        guard_ok;
  logic        ended;
  lane_res_t   res;

  assign length   = ctl_i.now_ms - start_q;
  assign guard_ok = (ctl_i.now_ms - rel_q) >= debounce_ms_i;
  assign ended    = latch_q || !ctl_i.level;

  // next state and events of this button
  always_comb begin
    mode_d   = mode_q;
    latch_d  = latch_q;
    start_d  = start_q;
    rel_d    = rel_q;
    res      = '0;
    res.busy = (mode_q != MODE_REST);
    if (ctl_i.accept) begin
      if (!ctl_i.poll) begin
        if (ctl_i.sel) begin
          if (ctl_i.level) begin
            if (mode_q == MODE_REST && guard_ok) begin
              latch_d    = 1'b0;
              mode_d     = MODE_CAUGHT;
              start_d    = ctl_i.now_ms;
              res.caught = 1'b1;
            end
          end else begin
            rel_d = ctl_i.now_ms;
            if (mode_q != MODE_REST) latch_d = 1'b1;
          end
        end
      end else if (ctl_i.poll_en) begin
        case (mode_q)
          MODE_CAUGHT: begin
            res.code[0]  = EV_DOWN;
            res.n        = 2'd1;
            mode_d       = MODE_UNFIRED;
            res.awaiting = 1'b1;
          end
          MODE_UNFIRED: begin
            if (ended) begin
              latch_d     = 1'b0;
              mode_d      = MODE_REST;
              res.code[0] = EV_UP;
              res.n       = 2'd1;
              if (length > debounce_ms_i && (latch_q || length < longpress_ms_i)) begin
                res.code[1] = EV_SHORT;
                res.n       = 2'd2;
              end
              // press already held again after the release
              if (ctl_i.level && guard_ok) begin
                mode_d       = MODE_CAUGHT;
                start_d      = ctl_i.now_ms;
                res.awaiting = 1'b1;
              end
            end else begin
              res.awaiting = 1'b1;
              if (length >= longpress_ms_i) begin
                mode_d      = MODE_FIRED;
                res.code[0] = EV_LONG;
                res.n       = 2'd1;
              end
            end
          end
          MODE_FIRED: begin
            if (ended) begin
              latch_d     = 1'b0;
              mode_d      = MODE_REST;
              res.code[0] = EV_UP;
              res.n       = 2'd1;
            end else begin
              res.awaiting = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (ctl_i.force_rest) mode_d = MODE_REST;
      end
    end
  end

  assign res_o = res;

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_REST;
      latch_q <= 1'b0;
      start_q <= '0;
      rel_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      latch_q <= latch_d;
      start_q <= start_d;
      rel_q   <= rel_d;
    end
  end

endmodule

@@ hw/rtl/tbpc_merge.sv @@
module tbpc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tbpc_pkg::lane_res_t lane_res_i [tbpc_pkg::NUM_BUTTONS],
  output logic                busy_o,
  output logic                ev_valid_o,
  input  logic                ev_ready_i,
  output tbpc_pkg::event_t    ev_o,
  output logic                ev_last_o
);
  import tbpc_pkg::*;

  event_t              slot_ev [MAX_EV];
  logic [EV_CNT_W-1:0] new_cnt;
  event_t              ev_q [MAX_EV];
  logic [EV_CNT_W-1:0] cnt_q;
  logic [EV_IDX_W-1:0] rd_q;
  logic                drain;
  logic                at_last;
  logic                out_valid_q;
  event_t              out_ev_q;
  logic                out_last_q;

  // pack lane events in button order, lane zero first
  always_comb begin
    logic [EV_CNT_W-1:0] off;
    off = '0;
    for (int k = 0; k < MAX_EV; k++) slot_ev[k] = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      for (int j = 0; j < LANE_EV; j++) begin
        if (2'(j) < lane_res_i[b].n) begin
          slot_ev[off[EV_IDX_W-1:0]] = '{button: 1'(b), code: lane_res_i[b].code[j]};
          off = off + 1'b1;
        end
      end
    end
    new_cnt = off;
  end

  assign busy_o  = (cnt_q != '0);
  assign drain   = busy_o && (!out_valid_q || ev_ready_i);
  assign at_last = (EV_CNT_W'(rd_q) == cnt_q - 1'b1);

  // event batch of one poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= new_cnt;
      rd_q  <= '0;
    end else if (drain) begin
      if (at_last) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) ev_q <= slot_ev;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q <= 1'b1;
    end else if (ev_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_ev_q   <= ev_q[rd_q];
      out_last_q <= at_last;
    end
  end

  assign ev_valid_o = out_valid_q;
  assign ev_o       = out_ev_q;
  assign ev_last_o  = out_last_q;

  a_load_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> cnt_q == '0) else $error("batch loaded while events pending");

  a_ptr_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> EV_CNT_W'(rd_q) < cnt_q) else $error("read pointer past batch");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == $past(new_cnt)) else $error("batch count lost");

endmodule

@@ hw/rtl/two_button_press_classifier_core.sv @@
// channel   direction  transaction contents
// s_axis    in         tuser: req_type, which_button; tdata: pressed_0, pressed_1, now_ms
// m_axis    out        tdata: button_id, event_code; tlast: last_event
// apb       in         registers debounce_ms_0, longpress_ms_0, debounce_ms_1, longpress_ms_1
//
// an edge or poll transaction updates the button lanes in the cycle it is accepted
// a poll's events (up to four) leave one per cycle from the batch buffer and s_axis_tready
// is low while that batch drains (an edge or an eventless poll leaves it high);
// m_axis_tready low stretches the drain
// the output register holds a result under stall while the next transaction is taken
// reset clears all press state, timestamps, polling and registers to zero
module two_button_press_classifier_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,   // pressed_0, pressed_1, now_ms[31:0], zero pad
  input  logic [1:0]                  s_axis_tuser,   // req_type, which_button
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // button_id, event_code[1:0], zero pad
  output logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbpc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tbpc_pkg::*;

  logic [31:0] debounce_q [NUM_BUTTONS];
  logic [31:0] longpress_q [NUM_BUTTONS];
  logic [1:0]  reg_idx;
  logic        cfg_wr;
  logic        accept;
  logic        is_poll;
  logic [1:0]  pins;
  logic        busy;
  logic        polling_q, polling_d;
  logic        any_await, any_caught, any_busy;
  logic        force_rest;
  lane_ctl_t   lane_ctl [NUM_BUTTONS];
  lane_res_t   lane_res [NUM_BUTTONS];
  event_t      out_ev;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        debounce_q[b]  <= '0;
        longpress_q[b] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE_0:  debounce_q[0]  <= pwdata;
        REG_LONGPRESS_0: longpress_q[0] <= pwdata;
        REG_DEBOUNCE_1:  debounce_q[1]  <= pwdata;
        REG_LONGPRESS_1: longpress_q[1] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE_0:  prdata = debounce_q[0];
      REG_LONGPRESS_0: prdata = longpress_q[0];
      REG_DEBOUNCE_1:  prdata = debounce_q[1];
      REG_LONGPRESS_1: prdata = longpress_q[1];
      default:         prdata = '0;
    endcase
  end

  // input handshake
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_poll       = s_axis_tuser[0];
  assign pins          = s_axis_tdata[1:0];

  // combine lane status
  always_comb begin
    any_await  = 1'b0;
    any_caught = 1'b0;
    any_busy   = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      any_await  = any_await  | lane_res[b].awaiting;
      any_caught = any_caught | lane_res[b].caught;
      any_busy   = any_busy   | lane_res[b].busy;
    end
  end

  assign force_rest = accept && is_poll && polling_q && !any_await;

  // button lanes
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    assign lane_ctl[g] = '{
      accept:     accept,
      poll:       is_poll,
      sel:        (s_axis_tuser[1] == 1'(g)),
      level:      (g < 2) ? pins[g] : 1'b0,
      poll_en:    polling_q,
      force_rest: force_rest,
      now_ms:     s_axis_tdata[33:2]
    };

    tbpc_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (lane_ctl[g]),
      .debounce_ms_i  (debounce_q[g]),
      .longpress_ms_i (longpress_q[g]),
      .res_o          (lane_res[g])
    );
  end

  // polling runs from an accepted press until no button needs it
  always_comb begin
    polling_d = polling_q;
    if (accept && !is_poll && any_caught) polling_d = 1'b1;
    else if (force_rest) polling_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) polling_q <= 1'b0;
    else         polling_q <= polling_d;
  end

  // event serializer
  tbpc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && is_poll && polling_q),
    .lane_res_i (lane_res),
    .busy_o     (busy),
    .ev_valid_o (m_axis_tvalid),
    .ev_ready_i (m_axis_tready),
    .ev_o       (out_ev),
    .ev_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_ev.code, out_ev.button};

  a_busy_needs_polling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_busy |-> polling_q) else $error("button active with polling off");

  a_no_take_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept) else $error("transaction taken while events drain");

endmodule

@@ tb/two_button_press_classifier_core_tb.sv @@
`timescale 1ns / 1ps

module two_button_press_classifier_core_tb;
  import tbpc_pkg::*;

  // request kinds carried in tuser bit 0
  localparam bit REQ_EDGE = 1'b0;
  localparam bit REQ_POLL = 1'b1;

  // cycles with no transaction on either stream before the run is abandoned
  localparam int QUIET_LIMIT = 3000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       button;
    logic [1:0] code;
    logic       last;
  } press_event_t;

  // tracks both button lanes and the events they still owe the output stream
  class press_event_checker;
    bit [31:0]    debounce_ms [NUM_BUTTONS];
    bit [31:0]    longpress_ms [NUM_BUTTONS];
    bit [1:0]     mode [NUM_BUTTONS];
    bit           latched [NUM_BUTTONS];
    bit [31:0]    press_ms [NUM_BUTTONS];
    bit [31:0]    release_ms [NUM_BUTTONS];
    bit           polling;
    press_event_t awaited_events [$];
    int           errors;

    function void set_timer(logic [1:0] idx, bit [31:0] value);
      case (idx)
        REG_DEBOUNCE_0:  debounce_ms[0] = value;
        REG_LONGPRESS_0: longpress_ms[0] = value;
        REG_DEBOUNCE_1:  debounce_ms[1] = value;
        REG_LONGPRESS_1: longpress_ms[1] = value;
        default: ;
      endcase
    endfunction

    // advance the lanes for one accepted transaction; returns 0 if it had no effect
    function bit note_item(bit req, bit btn, bit [1:0] lv, bit [31:0] now);
      press_event_t batch [$];
      bit           awaiting;
      bit           saw;
      bit           lane;
      bit [31:0]    held;
      bit [31:0]    since;
      int           b;
      awaiting = 1'b0;
      if (req == REQ_EDGE) begin
        since = now - release_ms[btn];
        if (lv[btn]) begin
          // press refused when busy or inside the debounce guard
          if (mode[btn] != MODE_REST || since < debounce_ms[btn]) return 1'b0;
          latched[btn] = 1'b0;
          mode[btn] = MODE_CAUGHT;
          press_ms[btn] = now;
          polling = 1'b1;
        end else begin
          release_ms[btn] = now;
          if (mode[btn] != MODE_REST) latched[btn] = 1'b1;
        end
        return 1'b1;
      end
      if (!polling) return 1'b0;
      for (b = 0; b < NUM_BUTTONS; b++) begin
        lane = b[0];
        held = now - press_ms[b];
        since = now - release_ms[b];
        case (mode[b])
          MODE_CAUGHT: begin
            batch.push_back('{lane, EV_DOWN, 1'b0});
            mode[b] = MODE_UNFIRED;
            awaiting = 1'b1;
          end
          MODE_UNFIRED: begin
            if (latched[b] || !lv[b]) begin
              saw = latched[b];
              latched[b] = 1'b0;
              batch.push_back('{lane, EV_UP, 1'b0});
              mode[b] = MODE_REST;
              if (held > debounce_ms[b] && (saw || held < longpress_ms[b]))
                batch.push_back('{lane, EV_SHORT, 1'b0});
              // pin already down again: take the new press now
              if (lv[b] && since >= debounce_ms[b]) begin
                mode[b] = MODE_CAUGHT;
                press_ms[b] = now;
                awaiting = 1'b1;
              end
            end else begin
              awaiting = 1'b1;
              if (held >= longpress_ms[b]) begin
                mode[b] = MODE_FIRED;
                batch.push_back('{lane, EV_LONG, 1'b0});
              end
            end
          end
          MODE_FIRED: begin
            if (latched[b] || !lv[b]) begin
              latched[b] = 1'b0;
              mode[b] = MODE_REST;
              batch.push_back('{lane, EV_UP, 1'b0});
            end else begin
              awaiting = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (!awaiting) begin
        polling = 1'b0;
        for (b = 0; b < NUM_BUTTONS; b++) mode[b] = MODE_REST;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) awaited_events.push_back(batch[i]);
      return 1'b1;
    endfunction

    // compare one output transaction with the oldest owed event
    function void check_event(logic btn, logic [1:0] code, logic last);
      press_event_t want;
      if (awaited_events.size() == 0) begin
        $error("event with none expected: button_id %0d event_code %0d last_event %0d",
               btn, code, last);
        errors++;
        return;
      end
      want = awaited_events.pop_front();
      if (btn !== want.button) begin
        $error("button_id mismatch: expected %0d, actual %0d", want.button, btn);
        errors++;
      end
      if (code !== want.code) begin
        $error("event_code mismatch: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_event mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;   // pressed_0, pressed_1, now_ms[31:0], zero pad
  logic [1:0]        s_axis_tuser;   // req_type, which_button
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // button_id, event_code[1:0], zero pad
  logic              m_axis_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  press_event_checker sb = new();

  bit [1:0]  pins;
  bit [31:0] clock_ms;
  bit        tx_burst;
  bit        rx_burst;
  bit        rx_hold;
  int        quiet_cycles;

  two_button_press_classifier_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output checking and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event(m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // event receiver with random stalls and one long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      if ($urandom_range(0, 14) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // one input transaction, after a random gap
  task automatic send_item(input bit req, input bit btn, input bit [1:0] lv,
                           input bit [31:0] t, output bit acted);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {btn, req};
    s_axis_tdata <= {6'b0, t, lv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    acted = sb.note_item(req, btn, lv, t);
  endtask

  // write all four timing registers
  task automatic program_timers(input bit [31:0] deb0, input bit [31:0] lp0,
                                input bit [31:0] deb1, input bit [31:0] lp1);
    logic [1:0] regs [4];
    bit [31:0]  vals [4];
    int         r;
    regs = '{REG_DEBOUNCE_0, REG_LONGPRESS_0, REG_DEBOUNCE_1, REG_LONGPRESS_1};
    vals = '{deb0, lp0, deb1, lp1};
    for (r = 0; r < 4; r++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {regs[r], 2'b00};
      pwdata <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      sb.set_timer(regs[r], vals[r]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stop offering and wait until every owed event has left
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // hand-picked presses; timers debounce 3/40 on button zero, 0/max on button one
  task automatic directed_presses();
    bit ign;
    send_item(REQ_POLL, 1'b0, 2'b00, 32'hFFFF_FFFF, ign);  // poll while idle
    send_item(REQ_EDGE, 1'b0, 2'b01, 32'd100, ign);
    send_item(REQ_POLL, 1'b0, 2'b01, 32'd102, ign);        // down
    send_item(REQ_POLL, 1'b0, 2'b01, 32'd110, ign);        // still held
    send_item(REQ_EDGE, 1'b0, 2'b00, 32'd120, ign);        // release latched
    send_item(REQ_POLL, 1'b0, 2'b00, 32'd121, ign);        // up, short
    send_item(REQ_EDGE, 1'b0, 2'b01, 32'd122, ign);        // inside debounce guard
    send_item(REQ_EDGE, 1'b0, 2'b01, 32'd124, ign);
    send_item(REQ_EDGE, 1'b1, 2'b11, 32'd124, ign);
    send_item(REQ_POLL, 1'b0, 2'b11, 32'd125, ign);        // down on both
    send_item(REQ_POLL, 1'b1, 2'b11, 32'd170, ign);        // long press on zero
    send_item(REQ_EDGE, 1'b0, 2'b10, 32'd190, ign);
    send_item(REQ_POLL, 1'b0, 2'b10, 32'd196, ign);        // up after long
    send_item(REQ_EDGE, 1'b1, 2'b00, 32'd200, ign);
    send_item(REQ_EDGE, 1'b1, 2'b10, 32'd201, ign);        // press while busy
    send_item(REQ_POLL, 1'b0, 2'b10, 32'd202, ign);        // up, short, re-press
    send_item(REQ_POLL, 1'b0, 2'b10, 32'd203, ign);        // down of re-press
    send_item(REQ_EDGE, 1'b1, 2'b00, 32'd210, ign);
    send_item(REQ_POLL, 1'b0, 2'b00, 32'd211, ign);
    send_item(REQ_EDGE, 1'b0, 2'b01, 32'd400, ign);
    send_item(REQ_EDGE, 1'b1, 2'b11, 32'd400, ign);
    send_item(REQ_POLL, 1'b0, 2'b11, 32'd401, ign);
    send_item(REQ_POLL, 1'b0, 2'b00, 32'd410, ign);        // four events in one poll
    send_item(REQ_EDGE, 1'b0, 2'b01, 32'hFFFF_FFF0, ign);
    send_item(REQ_POLL, 1'b0, 2'b01, 32'hFFFF_FFF8, ign);
    send_item(REQ_POLL, 1'b0, 2'b01, 32'h0000_0020, ign);  // long across the wrap
    send_item(REQ_POLL, 1'b0, 2'b00, 32'h0000_0030, ign);
  endtask

  // mostly clean press / poll / release sequences, some noise and glitches
  task automatic random_presses(input int count, input int pace);
    int       done;
    int       pick;
    bit       btn;
    bit       req;
    bit [1:0] lv;
    bit       acted;
    done = 0;
    clock_ms = $urandom;
    while (done < count) begin
      if ($urandom_range(0, 14) == 0) tx_burst = !tx_burst;
      pick = $urandom_range(0, 99);
      btn = 1'($urandom_range(0, 1));
      req = REQ_POLL;
      lv = pins;
      if (pick < 8) begin
        req = 1'($urandom_range(0, 1));
        lv = 2'($urandom_range(0, 3));
      end else if (pick < 40) begin
        pins[btn] = !pins[btn];
        lv = pins;
        req = REQ_EDGE;
      end else if (pick < 45) begin
        req = REQ_EDGE;          // bounce: same level again
      end else if (pick < 50) begin
        lv = 2'($urandom_range(0, 3));
      end
      send_item(req, btn, lv, clock_ms, acted);
      done++;
      if ($urandom_range(0, 29) == 0) clock_ms += $urandom;
      else clock_ms += $urandom_range(0, pace);
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_timers(32'd3, 32'd40, 32'd0, 32'hFFFF_FFFF);
    directed_presses();
    drain_stream();

    program_timers(32'd10, 32'd100, 32'd5, 32'd60);
    random_presses(70, 40);
    drain_stream();

    program_timers(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_presses(50, 20);
    drain_stream();

    // receiver backs off for a long stretch while transactions keep coming
    program_timers(32'd20, 32'd200, 32'd1, 32'd30);
    rx_hold = 1'b1;
    random_presses(80, 60);
    drain_stream();

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ two_button_press_classifier_core.f @@
hw/rtl/tbpc_pkg.sv
hw/rtl/tbpc_lane.sv
hw/rtl/tbpc_merge.sv
hw/rtl/two_button_press_classifier_core.sv
tb/two_button_press_classifier_core_tb.sv
